// ===== rtl/spatial_hash_neighbor_grid_macros.svh =====
// Assertion macros for the spatial hash neighbour grid.
// Taken in by the top level; no other dependencies.
`ifndef SPATIAL_HASH_NEIGHBOR_GRID_MACROS_SVH
`define SPATIAL_HASH_NEIGHBOR_GRID_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SHNG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SHNG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHNG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SHNG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/shng_pkg.sv =====
// Shared types and constants of the spatial hash neighbour grid.
// Used by the controller, the datapath and the top level.
package shng_pkg;

  localparam int TABLE_KEYS_DEF   = 64;
  localparam int BUCKET_DEPTH_DEF = 7;
  localparam int ID_BITS_DEF      = 16;

  localparam int POS_W  = 24;
  localparam int CS_W   = 23;
  localparam int KEY_W  = 32;
  localparam int OID_W  = 16;
  localparam int IID_W  = 16;
  localparam logic [CS_W-1:0] CELL_SIZE_RST = 23'd256;
  localparam logic [KEY_W-1:0] HASH_MUL_X = 32'd73856093;
  localparam logic [KEY_W-1:0] HASH_MUL_Y = 32'd19349663;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_BUCKET_FULL = 2'd1,
    STS_TABLE_FULL  = 2'd2
  } sts_e;

  typedef enum logic [3:0] {
    S_IDLE, S_MISC, S_DIV, S_COORD, S_HASH, S_SRD, S_SCMP,
    S_INS, S_QRD, S_QWAIT, S_NBNEXT, S_FIN
  } state_e;

  typedef struct packed {
    logic cap;
    logic div_step;
    logic nb_init;
    logic nb_next;
    logic coord;
    logic hash;
    logic scan_init;
    logic scan_cmp;
    logic ins_commit;
    logic id_init;
    logic id_rd;
    logic pend_load;
    logic push_misc;
    logic push_fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       div_last;
    logic       scan_hit;
    logic       scan_end;
    logic       more_ids;
    logic       nb_last;
    logic       pend_valid;
    logic       out_free;
  } dp_sts_t;

endpackage

// ===== rtl/shng_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module shng_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/shng_ctrl.sv =====
// Controller state machine of the spatial hash neighbour grid.
// Depends on shng_pkg; drives the datapath by command signals.
module shng_ctrl import shng_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [1:0] in_act_i,
  output logic      in_ready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          case (act_e'(in_act_i))
            ACT_INSERT, ACT_QUERY: state_d = S_DIV;
            default: state_d = S_MISC;
          endcase
        end
      end
      S_MISC: begin
        if (sts_i.out_free) begin
          cmd_o.push_misc = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.nb_init = 1'b1;
          state_d = S_COORD;
        end
      end
      S_COORD: begin
        cmd_o.coord = 1'b1;
        state_d = S_HASH;
      end
      S_HASH: begin
        cmd_o.hash      = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d = S_SRD;
      end
      S_SRD: begin
        state_d = S_SCMP;
      end
      S_SCMP: begin
        cmd_o.scan_cmp = 1'b1;
        if (sts_i.scan_hit || sts_i.scan_end) begin
          if (act_e'(sts_i.act) == ACT_INSERT) begin
            state_d = S_INS;
          end else if (sts_i.scan_hit) begin
            cmd_o.id_init = 1'b1;
            state_d = S_QRD;
          end else begin
            state_d = S_NBNEXT;
          end
        end else begin
          state_d = S_SRD;
        end
      end
      S_INS: begin
        if (sts_i.out_free) begin
          cmd_o.ins_commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_QRD: begin
        if (sts_i.more_ids) begin
          cmd_o.id_rd = 1'b1;
          state_d = S_QWAIT;
        end else begin
          state_d = S_NBNEXT;
        end
      end
      S_QWAIT: begin
        if (sts_i.out_free || !sts_i.pend_valid) begin
          cmd_o.pend_load = 1'b1;
          state_d = S_QRD;
        end
      end
      S_NBNEXT: begin
        if (sts_i.nb_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.nb_next = 1'b1;
          state_d = S_COORD;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.push_fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/shng_dp.sv =====
// Datapath of the spatial hash neighbour grid: dividers, hash, key search,
// buckets and output register. Depends on shng_pkg and shng_ram.
module shng_dp import shng_pkg::*; #(
  parameter int TABLE_KEYS   = TABLE_KEYS_DEF,
  parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
  parameter int ID_BITS      = ID_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_sts_t           sts_o,
  input  logic [63:0]       in_data_i,
  input  logic [1:0]        in_act_i,
  input  logic              cfg_we_i,
  input  logic [CS_W-1:0]   cfg_wdata_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [OID_W-1:0]  out_id_o,
  output logic              out_iv_o,
  output logic [1:0]        out_st_o,
  output logic              out_last_o
);
  localparam int KAW   = $clog2(TABLE_KEYS);
  localparam int CW    = $clog2(BUCKET_DEPTH + 1);
  localparam int BDEP  = TABLE_KEYS * BUCKET_DEPTH;
  localparam int BAW   = $clog2(BDEP);
  localparam int CNT_W = $clog2(POS_W);

  logic [CS_W-1:0]    cell_size_q;
  logic [1:0]         act_q;
  logic [ID_BITS-1:0] id_q;
  logic               negx_q, negy_q;
  logic [POS_W-1:0]   quox_q, quoy_q;
  logic [CS_W-1:0]    remx_q, remy_q;
  logic [CNT_W-1:0]   divcnt_q;
  logic [1:0]         dx_q, dy_q;
  logic [KEY_W-1:0]   cox_q, coy_q, hx_q, hy_q;
  logic [KAW-1:0]     scan_q, slot_q, free_slot_q;
  logic               found_q, free_found_q;
  logic [CW-1:0]      j_q;
  logic               pend_valid_q;
  logic [ID_BITS-1:0] pend_id_q;
  logic               out_valid_q, out_iv_q, out_last_q;
  logic [OID_W-1:0]   out_id_q;
  logic [1:0]         out_st_q;
  logic               valid_q [TABLE_KEYS];
  logic [CW-1:0]      cnt_q [TABLE_KEYS];

  logic [CS_W-1:0]    div_c;
  logic [POS_W-1:0]   px, py, magx, magy;
  logic [POS_W-1:0]   tx, ty;
  logic               gex, gey;
  logic [POS_W:0]     cx, cy;
  logic [KEY_W-1:0]   key, key_rdata;
  logic               hit;
  logic               push;
  logic [OID_W-1:0]   push_id;
  logic               push_iv, push_last;
  logic [1:0]         push_st;
  logic [KAW-1:0]     ins_slot;
  logic               key_we, bkt_we, out_free;
  logic [CW-1:0]      ins_pos;
  logic [BAW-1:0]     bkt_waddr, bkt_raddr;
  logic [ID_BITS-1:0] bkt_rdata;

  assign div_c = (cell_size_q == '0) ? CS_W'(1) : cell_size_q;
  assign px    = in_data_i[39:16];
  assign py    = in_data_i[63:40];
  assign magx  = px[POS_W-1] ? (~px + POS_W'(1)) : px;
  assign magy  = py[POS_W-1] ? (~py + POS_W'(1)) : py;
  assign tx    = {remx_q, quox_q[POS_W-1]};
  assign ty    = {remy_q, quoy_q[POS_W-1]};
  assign gex   = tx >= {1'b0, div_c};
  assign gey   = ty >= {1'b0, div_c};

  always_comb begin
    cx = {1'b0, quox_q};
    cy = {1'b0, quoy_q};
    if (negx_q) begin
      cx = ~cx + (POS_W+1)'(remx_q == '0);
    end
    if (negy_q) begin
      cy = ~cy + (POS_W+1)'(remy_q == '0);
    end
  end

  assign key = hx_q ^ hy_q;
  assign hit = valid_q[scan_q] && (key_rdata == key);
  assign out_free = !out_valid_q || out_ready_i;

  assign ins_slot = found_q ? slot_q : free_slot_q;
  assign ins_pos  = found_q ? cnt_q[slot_q] : '0;

  always_comb begin
    key_we  = 1'b0;
    bkt_we  = 1'b0;
    push    = 1'b0;
    push_id = '0;
    push_iv = 1'b0;
    push_st = STS_OK;
    push_last = 1'b1;
    if (cmd_i.ins_commit) begin
      push = 1'b1;
      if (found_q) begin
        if (cnt_q[slot_q] >= CW'(BUCKET_DEPTH)) begin
          push_st = STS_BUCKET_FULL;
        end else begin
          bkt_we = 1'b1;
        end
      end else if (free_found_q) begin
        key_we = 1'b1;
        bkt_we = 1'b1;
      end else begin
        push_st = STS_TABLE_FULL;
      end
    end
    if (cmd_i.push_misc) begin
      push = 1'b1;
    end
    if (cmd_i.pend_load && pend_valid_q) begin
      push      = 1'b1;
      push_id   = OID_W'(pend_id_q);
      push_iv   = 1'b1;
      push_last = 1'b0;
    end
    if (cmd_i.push_fin) begin
      push = 1'b1;
      if (pend_valid_q) begin
        push_id = OID_W'(pend_id_q);
        push_iv = 1'b1;
      end
    end
  end

  assign bkt_waddr = BAW'(ins_slot) * BAW'(BUCKET_DEPTH) + BAW'(ins_pos);
  assign bkt_raddr = BAW'(slot_q) * BAW'(BUCKET_DEPTH) + BAW'(j_q);

  shng_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_KEYS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (free_slot_q),
    .wdata_i (key),
    .re_i    (1'b1),
    .raddr_i (scan_q),
    .rdata_o (key_rdata)
  );

  shng_ram #(.WIDTH(ID_BITS), .DEPTH(BDEP)) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (id_q),
    .re_i    (cmd_i.id_rd),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q  <= CELL_SIZE_RST;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < TABLE_KEYS; i++) begin
        valid_q[i] <= 1'b0;
        cnt_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cell_size_q <= cfg_wdata_i;
      end
      if (cmd_i.cap) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.pend_load) begin
        pend_valid_q <= 1'b1;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.push_misc && act_e'(act_q) == ACT_CLEAR) begin
        for (int i = 0; i < TABLE_KEYS; i++) begin
          valid_q[i] <= 1'b0;
          cnt_q[i]   <= '0;
        end
      end
      if (key_we) begin
        valid_q[free_slot_q] <= 1'b1;
      end
      if (bkt_we) begin
        cnt_q[ins_slot] <= ins_pos + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      act_q    <= in_act_i;
      id_q     <= ID_BITS'(in_data_i[IID_W-1:0]);
      negx_q   <= px[POS_W-1];
      negy_q   <= py[POS_W-1];
      quox_q   <= magx;
      quoy_q   <= magy;
      remx_q   <= '0;
      remy_q   <= '0;
      divcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      remx_q   <= gex ? CS_W'(tx - {1'b0, div_c}) : tx[CS_W-1:0];
      remy_q   <= gey ? CS_W'(ty - {1'b0, div_c}) : ty[CS_W-1:0];
      quox_q   <= {quox_q[POS_W-2:0], gex};
      quoy_q   <= {quoy_q[POS_W-2:0], gey};
      divcnt_q <= divcnt_q + CNT_W'(1);
    end
    if (cmd_i.nb_init) begin
      dx_q <= (act_e'(act_q) == ACT_INSERT) ? 2'd1 : 2'd0;
      dy_q <= (act_e'(act_q) == ACT_INSERT) ? 2'd1 : 2'd0;
    end
    if (cmd_i.nb_next) begin
      if (dy_q == 2'd2) begin
        dy_q <= 2'd0;
        dx_q <= dx_q + 2'd1;
      end else begin
        dy_q <= dy_q + 2'd1;
      end
    end
    if (cmd_i.coord) begin
      cox_q <= {{(KEY_W-POS_W-1){cx[POS_W]}}, cx} + KEY_W'(dx_q) - KEY_W'(1);
      coy_q <= {{(KEY_W-POS_W-1){cy[POS_W]}}, cy} + KEY_W'(dy_q) - KEY_W'(1);
    end
    if (cmd_i.hash) begin
      hx_q <= cox_q * HASH_MUL_X;
      hy_q <= coy_q * HASH_MUL_Y;
    end
    if (cmd_i.scan_init) begin
      scan_q       <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end
    if (cmd_i.scan_cmp) begin
      scan_q <= scan_q + KAW'(1);
      if (hit) begin
        found_q <= 1'b1;
        slot_q  <= scan_q;
      end
      if (!valid_q[scan_q] && !free_found_q) begin
        free_found_q <= 1'b1;
        free_slot_q  <= scan_q;
      end
    end
    if (cmd_i.id_init) begin
      j_q <= '0;
    end
    if (cmd_i.id_rd) begin
      j_q <= j_q + CW'(1);
    end
    if (cmd_i.pend_load) begin
      pend_id_q <= bkt_rdata;
    end
    if (push) begin
      out_id_q   <= push_id;
      out_iv_q   <= push_iv;
      out_st_q   <= push_st;
      out_last_q <= push_last;
    end
  end

  assign sts_o.act        = act_q;
  assign sts_o.div_last   = divcnt_q == CNT_W'(POS_W - 1);
  assign sts_o.scan_hit   = hit;
  assign sts_o.scan_end   = scan_q == KAW'(TABLE_KEYS - 1);
  assign sts_o.more_ids   = j_q < cnt_q[slot_q];
  assign sts_o.nb_last    = (dx_q == 2'd2) && (dy_q == 2'd2);
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_id_o    = out_id_q;
  assign out_iv_o    = out_iv_q;
  assign out_st_o    = out_st_q;
  assign out_last_o  = out_last_q;
endmodule

// ===== rtl/spatial_hash_neighbor_grid.sv =====
// Top level of the spatial hash neighbour grid.
// Depends on shng_pkg, shng_ctrl, shng_dp and the assertion macro header.
//
//   channel  | dir | handshake             | payload
//   s_axis   | in  | tvalid/tready         | tdata id,x,y; tuser action
//   m_axis   | out | tvalid/tready         | tdata id; tuser valid,status; tlast
//   cfg      | in  | cfg_we_i              | cfg_wdata_i cell size
//
// Clear and the unused action pass through S_MISC only. An insert runs the 24-step
// dividers, then scans each key slot in S_SRD and S_SCMP via the single key RAM port.
// A query repeats the search for nine cells and reads found ids in S_QRD and S_QWAIT.
// Reset is asynchronous and leaves an empty table; the result register lets
// a new beat be taken while the last result waits, and stalls the search otherwise.
`include "spatial_hash_neighbor_grid_macros.svh"
module spatial_hash_neighbor_grid import shng_pkg::*; #(
  parameter int TABLE_KEYS   = TABLE_KEYS_DEF,
  parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
  parameter int ID_BITS      = ID_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [63:0]     s_axis_tdata,  // particle_id, pos_x, pos_y
  input  logic [1:0]      s_axis_tuser,  // action
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata,  // neighbor_id
  output logic [2:0]      m_axis_tuser,  // id_valid, status
  output logic            m_axis_tlast,
  input  logic            cfg_we_i,
  input  logic [CS_W-1:0] cfg_wdata_i
);
  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      out_iv;
  logic [1:0] out_st;

  shng_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_act_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  shng_dp #(
    .TABLE_KEYS   (TABLE_KEYS),
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .ID_BITS      (ID_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_act_i    (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_id_o    (m_axis_tdata),
    .out_iv_o    (out_iv),
    .out_st_o    (out_st),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = {out_st, out_iv};

  `SHNG_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
  `SHNG_ASSERT_SAME(a_push_when_free, clk_i, rst_ni, cmd.push_misc || cmd.push_fin || cmd.ins_commit, sts.out_free, "result register overwritten")
  `SHNG_ASSERT_SAME(a_found_id_ok, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[2:1] == 2'd0, "found id with non-zero status")
endmodule

// ===== test/spatial_hash_neighbor_grid_tb.sv =====
// Self-checking testbench for the spatial hash neighbour grid: directed and random
// beats, a bit-accurate predictor of the table, and random idling on both streams.
// Depends on shng_pkg and the spatial_hash_neighbor_grid top level only.
module spatial_hash_neighbor_grid_tb import shng_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NKEYS = 64;
  localparam int DEPTH = 7;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [15:0] id;
    logic        id_valid;
    logic [1:0]  status;
    logic        last;
  } grid_beat_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [63:0]     s_axis_tdata = '0;
  logic [1:0]      s_axis_tuser = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [15:0]     m_axis_tdata;
  logic [2:0]      m_axis_tuser;
  logic            m_axis_tlast;
  logic            cfg_we_i = 1'b0;
  logic [CS_W-1:0] cfg_wdata_i = '0;

  spatial_hash_neighbor_grid i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  // Predicted table contents.
  logic [CS_W-1:0] model_cell_size;
  logic [31:0]     model_keys [NKEYS];
  bit              model_key_used [NKEYS];
  int unsigned     model_count [NKEYS];
  logic [15:0]     model_ids [NKEYS][DEPTH];

  grid_beat_t expected_beats [$];
  int unsigned mismatches = 0;
  longint      cycles = 0;
  bit          calm = 1'b0;
  int unsigned hold_off = 0;
  int unsigned stall_left = 0;

  function automatic void queue_beat(logic [15:0] id, logic iv, logic [1:0] st,
                                     logic lst);
    grid_beat_t b;
    b = '{id, iv, st, lst};
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  function automatic longint cell_of(logic [23:0] pos);
    longint p, c, q;
    p = longint'(signed'(pos));
    c = (model_cell_size == 0) ? 1 : longint'(model_cell_size);
    q = p / c;
    if ((p % c) != 0 && p < 0) q -= 1;
    return q;
  endfunction

  function automatic logic [31:0] cell_key(longint cx, longint cy);
    logic [31:0] hx, hy, lx, ly;
    lx = cx[31:0];
    ly = cy[31:0];
    hx = lx * HASH_MUL_X;
    hy = ly * HASH_MUL_Y;
    return hx ^ hy;
  endfunction

  function automatic int find_slot(logic [31:0] key);
    for (int i = 0; i < NKEYS; i++) begin
      if (model_key_used[i] && model_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void predict_grid(logic [1:0] act, logic [15:0] pid,
                                       logic [23:0] px, logic [23:0] py);
    longint cx, cy;
    int s, n;
    logic [1:0] st;
    cx = cell_of(px);
    cy = cell_of(py);
    st = STS_OK;
    n = 0;
    case (act)
      ACT_CLEAR: begin
        for (int i = 0; i < NKEYS; i++) begin
          model_key_used[i] = 1'b0;
          model_count[i] = 0;
        end
      end
      ACT_INSERT: begin
        s = find_slot(cell_key(cx, cy));
        if (s < 0) begin
          for (int i = 0; i < NKEYS; i++) begin
            if (!model_key_used[i]) begin
              s = i;
              break;
            end
          end
          if (s < 0) begin
            st = STS_TABLE_FULL;
          end else begin
            model_key_used[s] = 1'b1;
            model_keys[s] = cell_key(cx, cy);
            model_count[s] = 0;
          end
        end
        if (s >= 0) begin
          if (model_count[s] >= DEPTH) begin
            st = STS_BUCKET_FULL;
          end else begin
            model_ids[s][model_count[s]] = pid;
            model_count[s]++;
          end
        end
      end
      ACT_QUERY: begin
        for (longint dx = -1; dx <= 1; dx++) begin
          for (longint dy = -1; dy <= 1; dy++) begin
            s = find_slot(cell_key(cx + dx, cy + dy));
            if (s >= 0) begin
              for (int j = 0; j < model_count[s]; j++) begin
                queue_beat(model_ids[s][j], 1'b1, STS_OK, 1'b0);
                n++;
              end
            end
          end
        end
        if (n > 0) expected_beats[$].last = 1'b1;
      end
      default: ;
    endcase
    if (n == 0) queue_beat(16'd0, 1'b0, st, 1'b1);
  endfunction

  // Result side: check each beat, then decide readiness for the next cycle.
  always @(posedge clk_i) begin
    grid_beat_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tuser[2:1], m_axis_tlast};
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %p", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", want, got);
        end
      end
    end
    if (hold_off > 0) begin
      hold_off--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(5) == 0) begin
      stall_left = $urandom_range(8, 1) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] act, logic [15:0] pid, logic [23:0] px,
                           logic [23:0] py);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(3) == 0) gap = $urandom_range(8, 1);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px, pid};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_grid(act, pid, px, py);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_cell_size(logic [CS_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_cell_size = value;
  endtask

  task automatic test_basic_actions();
    send_item(ACT_QUERY, 16'h0000, 24'h000000, 24'h000000);
    send_item(2'd3, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(ACT_INSERT, 16'h0000, 24'h800000, 24'h7FFFFF);
    send_item(ACT_INSERT, 16'hFFFF, 24'h7FFFFF, 24'h800000);
    send_item(ACT_INSERT, 16'hA5A5, 24'hFFFFFF, 24'h000000);
    send_item(ACT_QUERY, 16'h0000, 24'h800000, 24'h7FFFFF);
    send_item(ACT_QUERY, 16'h0000, 24'h7FFFFF, 24'h800000);
    send_item(ACT_QUERY, 16'h0000, 24'h000100, 24'h000000);
    send_item(ACT_CLEAR, 16'h1234, 24'h000000, 24'h000000);
    send_item(ACT_QUERY, 16'h0000, 24'hFFFFFF, 24'h000000);
  endtask

  task automatic test_bucket_overflow();
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(ACT_INSERT, 16'($urandom), 24'h000410, 24'hFFFC00);
    send_item(ACT_QUERY, 16'h0000, 24'h000500, 24'hFFFD00);
  endtask

  // Fills all nine neighbour cells, holds the result side off during the long
  // query, then fills the rest of the table and goes on until inserts are refused.
  task automatic test_full_table();
    set_cell_size(23'd1);
    send_item(ACT_CLEAR, 16'h0000, 24'h0, 24'h0);
    for (int dx = -1; dx <= 1; dx++)
      for (int dy = -1; dy <= 1; dy++)
        for (int k = 0; k < DEPTH; k++)
          send_item(ACT_INSERT, 16'($urandom), 24'(500 + dx), 24'(-300 + dy));
    hold_off = 400;
    for (int i = 0; i < 3; i++) send_item(ACT_QUERY, 16'h0, 24'd500, 24'(-300));
    for (int i = 0; i < NKEYS - 9 + 2; i++)
      send_item(ACT_INSERT, 16'($urandom), 24'(2000 + 3 * i), 24'd7000);
    send_item(ACT_INSERT, 16'h7777, 24'd500, 24'(-300));
    send_item(ACT_QUERY, 16'h0, 24'd2003, 24'd7000);
    send_item(ACT_CLEAR, 16'h0, 24'h0, 24'h0);
  endtask

  task automatic test_cell_size_extremes();
    logic [CS_W-1:0] sizes [3] = '{23'h7FFFFF, 23'd0, 23'd3};
    foreach (sizes[i]) begin
      set_cell_size(sizes[i]);
      send_item(ACT_INSERT, 16'($urandom), 24'h800000, 24'h7FFFFF);
      send_item(ACT_INSERT, 16'($urandom), 24'h000005, 24'hFFFFFB);
      send_item(ACT_QUERY, 16'h0, 24'h000000, 24'h000000);
      send_item(ACT_QUERY, 16'h0, 24'h800000, 24'h7FFFFF);
      send_item(ACT_CLEAR, 16'h0, 24'h0, 24'h0);
    end
  endtask

  task automatic test_random(int items, logic [CS_W-1:0] size);
    logic [1:0] act;
    logic [23:0] px, py;
    int pick;
    set_cell_size(size);
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) act = ACT_INSERT;
      else if (pick < 92) act = ACT_QUERY;
      else if (pick < 96) act = ACT_CLEAR;
      else act = 2'd3;
      if ($urandom_range(4) == 0) begin
        px = 24'($urandom);
        py = 24'($urandom);
      end else begin
        px = 24'(int'($urandom_range(6 * size)) - 3 * int'(size));
        py = 24'(int'($urandom_range(6 * size)) - 3 * int'(size));
      end
      send_item(act, 16'($urandom), px, py);
    end
  endtask

  initial begin
    model_cell_size = CELL_SIZE_RST;
    for (int i = 0; i < NKEYS; i++) begin
      model_key_used[i] = 1'b0;
      model_count[i] = 0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_actions();
    test_bucket_overflow();
    test_full_table();
    test_cell_size_extremes();
    test_random(50, 23'd256);
    test_random(50, 23'($urandom_range(200, 2)));
    drain();
    calm = 1'b1;
    test_random(40, 23'd37);
    drain();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/shng_pkg.sv
rtl/shng_ram.sv
rtl/shng_ctrl.sv
rtl/shng_dp.sv
rtl/spatial_hash_neighbor_grid.sv
test/spatial_hash_neighbor_grid_tb.sv
